@@ rtl/sfb_pkg.sv @@
// shared types, constants and helper functions of the sysex frame builder
package sfb_pkg;

  localparam int unsigned CNT_W  = 10;
  localparam int unsigned SUM_W  = 7;
  localparam int unsigned IDX_W  = 5;

  localparam logic [7:0] BYTE_SOF = 8'hf0;
  localparam logic [7:0] BYTE_EOF = 8'hf7;
  localparam logic [7:0] CMD_RQ1  = 8'h11;
  localparam logic [7:0] CMD_DT1  = 8'h12;
  localparam logic [7:0] MAKER_ID = 8'h41;
  localparam logic [7:0] CHK_BASE = 8'h80;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_RQ1   = 2'd2;

  localparam logic [0:0] REG_DEVICE_ID = 1'b0;
  localparam logic [0:0] REG_MODEL_ID  = 1'b1;

  // result counts per item kind
  localparam logic [IDX_W-1:0] N_START      = 5'd11;
  localparam logic [IDX_W-1:0] N_START_CLOSE = 5'd13;
  localparam logic [IDX_W-1:0] N_DATA       = 5'd1;
  localparam logic [IDX_W-1:0] N_DATA_CLOSE = 5'd3;
  localparam logic [IDX_W-1:0] N_RQ1        = 5'd17;
  localparam logic [IDX_W-1:0] N_ERR        = 5'd1;

  typedef enum logic [1:0] {
    BR_START,
    BR_DATA,
    BR_RQ1,
    BR_ERR
  } branch_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       frame_end;
    logic       error;
  } out_item_t;

  function automatic logic [SUM_W-1:0] sum_word(input logic [31:0] w);
    logic [9:0] s;
    s = 10'(w[31:24]) + 10'(w[23:16]) + 10'(w[15:8]) + 10'(w[7:0]);
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [7:0] check_of(input logic [SUM_W-1:0] s);
    return (s == '0) ? 8'h00 : CHK_BASE - 8'(s);
  endfunction

endpackage

@@ rtl/sfb_out_reg.sv @@
// output register of the result stream
module sfb_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              ld,
  input  sfb_pkg::out_item_t item,
  output logic              free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // out_byte
  output logic              m_tlast,
  output logic [1:0]        m_tuser    // frame_end, error
);
  import sfb_pkg::*;

  out_item_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      held <= item;
    end
  end

  assign m_tdata = held.out_byte;
  assign m_tlast = held.last;
  assign m_tuser = {held.error, held.frame_end};

endmodule

@@ rtl/sysex_frame_builder.sv @@
// top level of the sysex frame builder
//
// input stream: one item per handshake, tuser holds req_type, tdata holds
// address (bits 31:0), size (63:32) and data_byte (71:64).
// output stream: one frame byte per handshake in tdata, tlast marks the last
// result of an input item, tuser bit 0 flags the closing f7, bit 1 an error.
// configuration: cfg_we with cfg_index 0 writes device_id, 1 the model code.
//
// an accepted item sits in the input register and leaves as 1 to 17 results,
// one per cycle while the receiver does not stall; the first byte goes from
// the input register to the output register. a data item gives one result,
// or 3 when it closes the frame, a start item 11 or 13, a request item 17.
// the next item is taken in the same cycle as the last byte of the current
// one, so data bytes stream at one per cycle while the receiver keeps up.
// when the receiver stalls, the output register holds its byte and the
// sequencer waits; the input side waits until the current item's last byte
// is loaded.
// reset clears the frame state, device_id to 0x10 and the model code to zero.
module sysex_frame_builder #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // address, size, data_byte
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // frame_end, error
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import sfb_pkg::*;

  logic [7:0]       device_id;
  logic [23:0]      model_code;
  logic             frame_open;
  logic [CNT_W-1:0] bytes_left;
  logic [SUM_W-1:0] running_sum;

  logic             busy;
  logic [IDX_W-1:0] idx;
  logic [1:0]       kind;
  logic [31:0]      addr;
  logic [31:0]      size;
  logic [7:0]       data;
  logic [SUM_W-1:0] addr_sum;
  logic [SUM_W-1:0] size_sum;
  logic             size_ok;
  logic             size_zero;

  branch_t          br;
  logic [IDX_W-1:0] n_res;
  logic             closing;
  logic             cur_last;
  logic [SUM_W-1:0] chk_sum;
  logic [SUM_W-1:0] data_sum;
  logic             out_free;
  logic             out_ld;
  logic             accept;
  out_item_t        item;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id  <= 8'h10;
      model_code <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEVICE_ID: device_id  <= cfg_wdata[7:0];
        REG_MODEL_ID:  model_code <= cfg_wdata;
        default:       device_id  <= device_id;
      endcase
    end
  end

  // item kind against the current frame state
  always_comb begin
    case (kind)
      REQ_START: br = (!frame_open && size_ok) ? BR_START : BR_ERR;
      REQ_DATA:  br = frame_open ? BR_DATA : BR_ERR;
      REQ_RQ1:   br = (!frame_open && size_ok) ? BR_RQ1 : BR_ERR;
      default:   br = BR_ERR;
    endcase
  end

  assign data_sum = running_sum + data[SUM_W-1:0];

  always_comb begin
    case (br)
      BR_START: begin
        closing = size_zero;
        n_res   = size_zero ? N_START_CLOSE : N_START;
        chk_sum = addr_sum;
      end
      BR_DATA: begin
        closing = (bytes_left == CNT_W'(1));
        n_res   = closing ? N_DATA_CLOSE : N_DATA;
        chk_sum = data_sum;
      end
      BR_RQ1: begin
        closing = 1'b1;
        n_res   = N_RQ1;
        chk_sum = addr_sum + size_sum;
      end
      default: begin
        closing = 1'b0;
        n_res   = N_ERR;
        chk_sum = '0;
      end
    endcase
  end

  assign cur_last = (idx == n_res - IDX_W'(1));
  assign out_ld   = busy && out_free;
  assign s_tready = !busy || (out_ld && cur_last);
  assign accept   = s_tvalid && s_tready;

  // byte of the current item at position idx
  always_comb begin
    item           = '0;
    item.last      = cur_last;
    if (br == BR_ERR) begin
      item.error = 1'b1;
    end else if (closing && cur_last) begin
      item.out_byte  = BYTE_EOF;
      item.frame_end = 1'b1;
    end else if (closing && idx == n_res - IDX_W'(2)) begin
      item.out_byte = check_of(chk_sum);
    end else if (br == BR_DATA) begin
      item.out_byte = data;
    end else begin
      case (idx)
        5'd0:    item.out_byte = BYTE_SOF;
        5'd1:    item.out_byte = MAKER_ID;
        5'd2:    item.out_byte = device_id;
        5'd3:    item.out_byte = model_code[23:16];
        5'd4:    item.out_byte = model_code[15:8];
        5'd5:    item.out_byte = model_code[7:0];
        5'd6:    item.out_byte = (br == BR_RQ1) ? CMD_RQ1 : CMD_DT1;
        5'd7:    item.out_byte = addr[31:24];
        5'd8:    item.out_byte = addr[23:16];
        5'd9:    item.out_byte = addr[15:8];
        5'd10:   item.out_byte = addr[7:0];
        5'd11:   item.out_byte = size[31:24];
        5'd12:   item.out_byte = size[23:16];
        5'd13:   item.out_byte = size[15:8];
        5'd14:   item.out_byte = size[7:0];
        default: item.out_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (out_ld && cur_last) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (out_ld) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind      <= s_tuser;
      addr      <= s_tdata[31:0];
      size      <= s_tdata[63:32];
      data      <= s_tdata[71:64];
      addr_sum  <= sum_word(s_tdata[31:0]);
      size_sum  <= sum_word(s_tdata[63:32]);
      size_ok   <= (s_tdata[63:32] <= 32'(MAX_PAYLOAD));
      size_zero <= (s_tdata[63:32] == 32'd0);
    end
  end

  // frame state moves on when an item's last byte goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      bytes_left  <= '0;
      running_sum <= '0;
    end else if (out_ld && cur_last) begin
      case (br)
        BR_START: begin
          if (!size_zero) begin
            frame_open  <= 1'b1;
            bytes_left  <= size[CNT_W-1:0];
            running_sum <= addr_sum;
          end
        end
        BR_DATA: begin
          if (closing) begin
            frame_open  <= 1'b0;
            bytes_left  <= '0;
            running_sum <= '0;
          end else begin
            bytes_left  <= bytes_left - CNT_W'(1);
            running_sum <= data_sum;
          end
        end
        default: begin
          frame_open <= frame_open;
        end
      endcase
    end
  end

  sfb_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .ld       (out_ld),
    .item     (item),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && idx == '0)
    else $error("item not started at position zero");

  a_open_has_count: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> bytes_left != '0)
    else $error("open frame with no bytes left");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (out_ld && br == BR_ERR) |-> cur_last)
    else $error("error result not last");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (out_ld && item.frame_end) |-> cur_last && item.out_byte == BYTE_EOF)
    else $error("frame end not on last byte");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx < N_RQ1)
    else $error("byte position out of range");
`endif

endmodule

@@ verif/testbench.sv @@
// testbench of the sysex frame builder: directed table and random frames checked byte by byte
`timescale 1ns / 1ps

module testbench;
  import sfb_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 512;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam out_item_t ERR_ITEM = '{8'h00, 1'b1, 1'b0, 1'b1};
  localparam out_item_t NO_ITEM = '{8'h00, 1'b0, 1'b0, 1'b0};

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] size;
    logic [7:0]  dat;
    logic        typed;
    out_item_t   want;
  } stim_row_t;

  localparam int N_ROWS = 22;
  localparam stim_row_t DIR_ROWS [0:N_ROWS-1] = '{
    '{REQ_DATA,   32'hffffffff, 32'hffffffff, 8'hff, 1'b1, ERR_ITEM},
    '{REQ_UNUSED, 32'h00000000, 32'h00000000, 8'h00, 1'b1, ERR_ITEM},
    '{REQ_START,  32'h00000000, 32'd513,      8'h00, 1'b1, ERR_ITEM},
    '{REQ_START,  32'hffffffff, 32'hffffffff, 8'hff, 1'b1, ERR_ITEM},
    '{REQ_RQ1,    32'h12345678, 32'd513,      8'h00, 1'b1, ERR_ITEM},
    '{REQ_RQ1,    32'h00000000, 32'h00000000, 8'hff, 1'b0, NO_ITEM},
    '{REQ_RQ1,    32'hffffffff, 32'd512,      8'h00, 1'b0, NO_ITEM},
    '{REQ_START,  32'h00000000, 32'h00000000, 8'hff, 1'b0, NO_ITEM},
    '{REQ_START,  32'hffffffff, 32'd3,        8'ha5, 1'b0, NO_ITEM},
    '{REQ_START,  32'h00000000, 32'h00000000, 8'h00, 1'b1, ERR_ITEM},
    '{REQ_RQ1,    32'h00000000, 32'h00000001, 8'h00, 1'b1, ERR_ITEM},
    '{REQ_UNUSED, 32'hffffffff, 32'hffffffff, 8'hff, 1'b1, ERR_ITEM},
    '{REQ_START,  32'h00000000, 32'hffffffff, 8'h00, 1'b1, ERR_ITEM},
    '{REQ_DATA,   32'hffffffff, 32'hffffffff, 8'h00, 1'b0, NO_ITEM},
    '{REQ_DATA,   32'h00000000, 32'h00000000, 8'hff, 1'b0, NO_ITEM},
    '{REQ_DATA,   32'h00000000, 32'h00000000, 8'h7f, 1'b0, NO_ITEM},
    '{REQ_START,  32'h01020304, 32'd1,        8'h00, 1'b0, NO_ITEM},
    '{REQ_DATA,   32'h00000000, 32'h00000000, 8'h80, 1'b0, NO_ITEM},
    '{REQ_START,  32'h7f000001, 32'd2,        8'h00, 1'b0, NO_ITEM},
    '{REQ_DATA,   32'h00000000, 32'h00000000, 8'h01, 1'b0, NO_ITEM},
    '{REQ_DATA,   32'h00000000, 32'h00000000, 8'h7e, 1'b0, NO_ITEM},
    '{REQ_DATA,   32'h55aa55aa, 32'haa55aa55, 8'h3c, 1'b1, ERR_ITEM}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [23:0] cfg_wdata;

  logic [7:0]  dev_reg;
  logic [23:0] model_reg;
  logic        cur_open;
  logic [9:0]  cur_left;
  logic [6:0]  cur_sum;

  out_item_t   step_bytes[$];
  out_item_t   pending[$];
  int          bad_cnt = 0;
  bit          idle_on = 1'b1;

  sysex_frame_builder #(.MAX_PAYLOAD(MAX_PAYLOAD)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic [6:0] byte_sum(input logic [31:0] w);
    logic [9:0] s;
    s = {2'b00, w[31:24]} + {2'b00, w[23:16]} + {2'b00, w[15:8]} + {2'b00, w[7:0]};
    return s[6:0];
  endfunction

  function automatic logic [7:0] chk_byte(input logic [6:0] s);
    return (s == 7'd0) ? 8'h00 : CHK_BASE - {1'b0, s};
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic fend);
    step_bytes.push_back(out_item_t'{b, 1'b0, fend, 1'b0});
  endfunction

  function automatic void push_header(input logic [7:0] cmd);
    push_byte(BYTE_SOF, 1'b0);
    push_byte(MAKER_ID, 1'b0);
    push_byte(dev_reg, 1'b0);
    push_byte(model_reg[23:16], 1'b0);
    push_byte(model_reg[15:8], 1'b0);
    push_byte(model_reg[7:0], 1'b0);
    push_byte(cmd, 1'b0);
  endfunction

  function automatic void push_word(input logic [31:0] w);
    push_byte(w[31:24], 1'b0);
    push_byte(w[23:16], 1'b0);
    push_byte(w[15:8], 1'b0);
    push_byte(w[7:0], 1'b0);
  endfunction

  function automatic void close_frame();
    push_byte(chk_byte(cur_sum), 1'b0);
    push_byte(BYTE_EOF, 1'b1);
    cur_open = 1'b0;
    cur_left = '0;
    cur_sum = '0;
  endfunction

  function automatic void predict_frame(input logic [1:0] kind, input logic [31:0] addr,
                                        input logic [31:0] size, input logic [7:0] dat);
    step_bytes.delete();
    if (kind == REQ_START && !cur_open && size <= MAX_PAYLOAD) begin
      push_header(CMD_DT1);
      push_word(addr);
      cur_sum = byte_sum(addr);
      cur_left = size[9:0];
      cur_open = 1'b1;
      if (cur_left == 10'd0) close_frame();
    end else if (kind == REQ_DATA && cur_open) begin
      push_byte(dat, 1'b0);
      cur_sum = 7'(cur_sum + dat);
      cur_left = cur_left - 10'd1;
      if (cur_left == 10'd0) close_frame();
    end else if (kind == REQ_RQ1 && !cur_open && size <= MAX_PAYLOAD) begin
      push_header(CMD_RQ1);
      push_word(addr);
      push_word(size);
      push_byte(chk_byte(7'(byte_sum(addr) + byte_sum(size))), 1'b0);
      push_byte(BYTE_EOF, 1'b1);
    end else begin
      step_bytes.push_back(ERR_ITEM);
    end
    step_bytes[step_bytes.size() - 1].last = 1'b1;
  endfunction

  function automatic void report_bad(input string what);
    if (bad_cnt < 10) $display("mismatch: %s", what);
    bad_cnt++;
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [31:0] addr,
                           input logic [31:0] size, input logic [7:0] dat,
                           input logic typed, input out_item_t want);
    while (idle_on && $urandom_range(0, 99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    predict_frame(kind, addr, size, dat);
    if (typed) pending.push_back(want);
    else foreach (step_bytes[k]) pending.push_back(step_bytes[k]);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {dat, size, addr};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_frames();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  task automatic set_config(input logic [7:0] dev, input logic [23:0] model);
    drain_frames();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_DEVICE_ID;
    cfg_wdata <= {16'($urandom), dev};
    @(posedge clk);
    cfg_index <= REG_MODEL_ID;
    cfg_wdata <= model;
    @(posedge clk);
    cfg_we <= 1'b0;
    dev_reg = dev;
    model_reg = model;
  endtask

  task automatic close_open_frame();
    while (cur_open) send_item(REQ_DATA, $urandom, $urandom, 8'($urandom), 1'b0, NO_ITEM);
  endtask

  task automatic run_random(input int count);
    int r;
    logic [31:0] big;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      do big = $urandom; while (big <= MAX_PAYLOAD);
      if ($urandom_range(0, 3) == 0) big = MAX_PAYLOAD + 1;
      if (r < 80) begin
        if (cur_open)
          send_item(REQ_DATA, $urandom, $urandom, 8'($urandom), 1'b0, NO_ITEM);
        else if ($urandom_range(0, 3) == 0)
          send_item(REQ_RQ1, $urandom, $urandom_range(0, MAX_PAYLOAD), 8'($urandom),
                    1'b0, NO_ITEM);
        else
          send_item(REQ_START, $urandom,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6),
                    8'($urandom), 1'b0, NO_ITEM);
      end else begin
        case ($urandom_range(0, 3))
          0: send_item(REQ_DATA, $urandom, $urandom, 8'($urandom), 1'b0, NO_ITEM);
          1: send_item(REQ_START, $urandom, $urandom_range(0, 4), 8'($urandom), 1'b0, NO_ITEM);
          2: send_item(($urandom_range(0, 1) == 0) ? REQ_START : REQ_RQ1, $urandom, big,
                       8'($urandom), 1'b0, NO_ITEM);
          default: send_item(REQ_UNUSED, $urandom, $urandom, 8'($urandom), 1'b0, NO_ITEM);
        endcase
      end
      if ($urandom_range(0, 49) == 0) drain_frames();
    end
    close_open_frame();
  endtask

  always @(posedge clk) begin : rx
    out_item_t want;
    out_item_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = out_item_t'{m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
      if (pending.size() == 0) begin
        report_bad($sformatf("unexpected item byte %h last %b end %b err %b",
                             got.out_byte, got.last, got.frame_end, got.error));
      end else begin
        want = pending.pop_front();
        if (got.out_byte !== want.out_byte || got.last !== want.last ||
            got.frame_end !== want.frame_end || got.error !== want.error)
          report_bad($sformatf("exp byte %h last %b end %b err %b, got byte %h last %b end %b err %b",
                               want.out_byte, want.last, want.frame_end, want.error,
                               got.out_byte, got.last, got.frame_end, got.error));
      end
    end
    m_tready <= !idle_on || ($urandom_range(0, 99) >= 16);
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= REQ_START;
    m_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_DEVICE_ID;
    cfg_wdata <= '0;
    dev_reg = 8'h10;
    model_reg = 24'h000000;
    cur_open = 1'b0;
    cur_left = '0;
    cur_sum = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++)
      send_item(DIR_ROWS[i].kind, DIR_ROWS[i].addr, DIR_ROWS[i].size, DIR_ROWS[i].dat,
                DIR_ROWS[i].typed, DIR_ROWS[i].want);

    set_config(8'h00, 24'h000000);
    run_random(26);

    set_config(8'hff, 24'hffffff);
    idle_on = 1'b0;
    run_random(26);
    idle_on = 1'b1;

    set_config(8'($urandom), 24'($urandom));
    run_random(26);

    set_config(8'h7f, 24'h800001);
    run_random(26);

    drain_frames();
    repeat (20) @(posedge clk);
    if (bad_cnt == 0 && pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
